### hw/rtl/terminal_line_editor_defines.svh
// assertion macros used by the terminal line editor checker
`ifndef TERMINAL_LINE_EDITOR_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_DEFINES_SVH

// same-cycle implication under reset
`define TLE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tle: same-cycle check failed");

// next-cycle implication under reset
`define TLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tle: next-cycle check failed");

`endif

### hw/rtl/tle_pkg.sv
// shared types, codes and constant tables of the terminal line editor
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

    localparam int LINE_LEN_DEF   = 32;
    localparam int HIST_DEPTH_DEF = 8;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_SEEN = 2'd1;
    localparam logic [1:0] ESC_CSI  = 2'd2;
    localparam logic [1:0] ESC_CSI3 = 2'd3;

    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_RIGHT = 4'd1;
    localparam logic [3:0] OP_LEFT  = 4'd2;
    localparam logic [3:0] OP_DEL   = 4'd3;
    localparam logic [3:0] OP_BKSP  = 4'd4;
    localparam logic [3:0] OP_INS   = 4'd5;
    localparam logic [3:0] OP_UP    = 4'd6;
    localparam logic [3:0] OP_DOWN  = 4'd7;
    localparam logic [3:0] OP_CR    = 4'd8;

    typedef struct packed {
        logic [4:0] pre_s;
        logic [4:0] pre_e;
        logic [4:0] post_s;
        logic [4:0] post_e;
    } prog_t;

    typedef struct packed {
        logic       idle;
        logic       emit;
        logic       src_rom;
        logic       kind;
        logic       last;
        logic       done;
        logic [4:0] rom_idx;
        logic       rd_last;
        logic       rc_write;
        logic       len_dec;
        logic       shift_left;
        logic       ptr_inc;
        logic       ptr_clr;
        logic       push;
        logic       mem_we;
        logic       line_clear;
    } cmd_t;

    typedef struct packed {
        logic [3:0] op;
        logic       out_free;
        logic       tail_empty;
        logic       tail_lastone;
        logic       trail_sp;
        logic       lead_sp;
        logic       len_zero;
        logic       hlen_ne;
        logic       byte_eq;
    } stat_t;

    // echo fragments: left, save+clreol, restore+right, clear line+prompt, newline
    function automatic logic [7:0] rom_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = CH_ESC;
            5'd1:    b = CH_LBRK;
            5'd2:    b = CH_D;
            5'd3:    b = CH_ESC;
            5'd4:    b = 8'h37;
            5'd5:    b = CH_ESC;
            5'd6:    b = CH_LBRK;
            5'd7:    b = 8'h4B;
            5'd8:    b = CH_ESC;
            5'd9:    b = 8'h38;
            5'd10:   b = CH_ESC;
            5'd11:   b = CH_LBRK;
            5'd12:   b = CH_C;
            5'd13:   b = CH_ESC;
            5'd14:   b = CH_LBRK;
            5'd15:   b = 8'h32;
            5'd16:   b = 8'h4B;
            5'd17:   b = CH_CR;
            5'd18:   b = 8'h5A;
            5'd19:   b = 8'h31;
            5'd20:   b = CH_SP;
            5'd21:   b = 8'h3E;
            5'd22:   b = CH_SP;
            5'd23:   b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // echo program per operation: fragment before the tail and after it
    function automatic prog_t prog_of(input logic [3:0] op);
        prog_t p;
        case (op)
            OP_LEFT:  p = '{5'd0,  5'd3,  5'd0, 5'd0};
            OP_RIGHT: p = '{5'd10, 5'd13, 5'd0, 5'd0};
            OP_BKSP:  p = '{5'd0,  5'd8,  5'd8, 5'd10};
            OP_DEL:   p = '{5'd3,  5'd8,  5'd8, 5'd10};
            OP_INS:   p = '{5'd3,  5'd8,  5'd8, 5'd13};
            OP_UP:    p = '{5'd13, 5'd23, 5'd0, 5'd0};
            OP_DOWN:  p = '{5'd13, 5'd23, 5'd0, 5'd0};
            OP_CR:    p = '{5'd23, 5'd24, 5'd0, 5'd0};
            default:  p = '{5'd0,  5'd0,  5'd0, 5'd0};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tle_datapath.sv
// line, history and output register datapath of the terminal line editor
`timescale 1ns / 1ps
`default_nettype none

module tle_datapath #(
    parameter int LINE_LEN   = tle_pkg::LINE_LEN_DEF,
    parameter int HIST_DEPTH = tle_pkg::HIST_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     rx_byte,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [7:0]     out_byte,
    output logic           out_kind,
    output logic           line_done,
    output logic           last,
    input  tle_pkg::cmd_t  cmd,
    output tle_pkg::stat_t stat
);
    import tle_pkg::*;

    localparam int CW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam int LW = $clog2(LINE_LEN + 1);
    localparam int HW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int RW = $clog2(HIST_DEPTH + 1);
    localparam int SW = RW + 1;
    localparam int MD = 1 << (HW + CW);
    localparam logic [LW-1:0] LEN_MAX  = LW'(LINE_LEN);
    localparam logic [RW-1:0] REC_MAX  = RW'(HIST_DEPTH);
    localparam logic [SW-1:0] H_S      = SW'(HIST_DEPTH);
    localparam logic [HW-1:0] HEAD_TOP = HW'(HIST_DEPTH - 1);

    logic [7:0]    line_reg  [LINE_LEN];
    logic [7:0]    line_next [LINE_LEN];
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] ptr_reg, ptr_next;
    logic [1:0]    esc_reg, esc_next;
    logic [RW-1:0] rec_reg, rec_next;
    logic [HW-1:0] head_reg, head_next;
    logic [HW-1:0] hp_reg, hp_next;
    logic [LW-1:0] hlen_reg [HIST_DEPTH];
    logic [7:0]    mem [MD];
    logic [7:0]    mem_q_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_kind_reg;
    logic          out_done_reg;
    logic          out_last_reg;

    logic          accept;
    logic [3:0]    op;
    logic [1:0]    esc_dec;
    logic          is_print;
    logic [LW-1:0] lenm1;
    logic [LW-1:0] rd_pos;
    logic [7:0]    line_rd;
    logic [SW-1:0] tgt_l;
    logic [SW-1:0] p_sum;
    logic [SW-1:0] p_wr;
    logic [SW-1:0] hl_sel;
    logic [LW-1:0] hlen_rd;
    logic [LW-1:0] ins_len;
    logic          rm_en;
    logic [LW-1:0] rm_pos;
    logic [HW-1:0] head_dec;
    logic [HW+CW-1:0] maddr;

    assign accept   = cmd.idle && in_valid;
    assign lenm1    = len_reg - 1'b1;
    assign rd_pos   = cmd.rd_last ? lenm1 : ptr_reg;
    assign line_rd  = line_reg[rd_pos[CW-1:0]];
    assign is_print = (rx_byte >= CH_SP) && (rx_byte <= CH_TILDE);
    assign head_dec = (head_reg == '0) ? HEAD_TOP : head_reg - 1'b1;
    assign maddr    = {hp_reg, ptr_reg[CW-1:0]};
    assign ins_len  = (len_reg < LEN_MAX) ? len_reg + 1'b1 : len_reg;

    // history length lookup, logical entry mapped around the ring head
    assign tgt_l  = SW'(rec_reg) - ((rx_byte == CH_B) ? SW'(2) : SW'(0));
    assign p_sum  = SW'(head_reg) + tgt_l;
    assign p_wr   = (p_sum >= H_S) ? p_sum - H_S : p_sum;
    assign hl_sel = cmd.idle ? p_wr : SW'(head_reg);
    assign hlen_rd = (hl_sel < H_S) ? hlen_reg[hl_sel[HW-1:0]] : '0;

    always_comb
    begin
        op      = OP_NONE;
        esc_dec = ESC_NONE;
        if (rx_byte == CH_ESC)
        begin
            esc_dec = ESC_SEEN;
        end
        else if (esc_reg == ESC_SEEN && rx_byte == CH_LBRK)
        begin
            esc_dec = ESC_CSI;
        end
        else if (esc_reg == ESC_CSI && rx_byte == CH_3)
        begin
            esc_dec = ESC_CSI3;
        end
        else if (esc_reg == ESC_CSI3 && rx_byte == CH_TILDE)
        begin
            op = OP_DEL;
        end
        else if (esc_reg == ESC_CSI && rx_byte == CH_C)
        begin
            if (cur_reg < len_reg)
                op = OP_RIGHT;
        end
        else if (esc_reg == ESC_CSI && rx_byte == CH_D)
        begin
            if (cur_reg != '0)
                op = OP_LEFT;
        end
        else if (esc_reg == ESC_CSI && rx_byte == CH_A)
        begin
            if (rec_reg < REC_MAX && hlen_rd != '0)
                op = OP_UP;
        end
        else if (esc_reg == ESC_CSI && rx_byte == CH_B)
        begin
            if (rec_reg > RW'(1) && hlen_rd != '0)
                op = OP_DOWN;
        end
        else if ((rx_byte == CH_BS || rx_byte == CH_DEL) && cur_reg != '0
                 && esc_reg == ESC_NONE)
        begin
            op = OP_BKSP;
        end
        else if (is_print && cur_reg < LEN_MAX && esc_reg == ESC_NONE)
        begin
            op = OP_INS;
        end
        else if (rx_byte == CH_CR)
        begin
            op = OP_CR;
        end
    end

    assign rm_en  = (accept && (op == OP_DEL || op == OP_BKSP)) || cmd.shift_left;
    assign rm_pos = cmd.shift_left ? '0 : ((op == OP_BKSP) ? cur_reg - 1'b1 : cur_reg);

    always_comb
    begin
        for (int i = 0; i < LINE_LEN; i++)
            line_next[i] = line_reg[i];
        if (accept && op == OP_INS)
        begin
            for (int i = 1; i < LINE_LEN; i++)
            begin
                if (LW'(i) > cur_reg && LW'(i) < ins_len)
                    line_next[i] = line_reg[i-1];
            end
            line_next[cur_reg[CW-1:0]] = rx_byte;
        end
        if (rm_en)
        begin
            for (int i = 0; i < LINE_LEN - 1; i++)
            begin
                if (LW'(i) >= rm_pos && LW'(i + 1) < len_reg)
                    line_next[i] = line_reg[i+1];
            end
        end
        if (cmd.rc_write)
            line_next[ptr_reg[CW-1:0]] = mem_q_reg;
    end

    always_comb
    begin
        len_next  = len_reg;
        cur_next  = cur_reg;
        ptr_next  = ptr_reg;
        esc_next  = esc_reg;
        rec_next  = rec_reg;
        hp_next   = hp_reg;
        head_next = head_reg;
        if (accept)
        begin
            esc_next = esc_dec;
            ptr_next = '0;
            case (op)
                OP_INS:
                begin
                    len_next = ins_len;
                    cur_next = cur_reg + 1'b1;
                    ptr_next = cur_reg;
                end
                OP_DEL:
                begin
                    if (rm_pos < len_reg)
                        len_next = len_reg - 1'b1;
                    ptr_next = cur_reg;
                end
                OP_BKSP:
                begin
                    len_next = len_reg - 1'b1;
                    cur_next = cur_reg - 1'b1;
                    ptr_next = cur_reg - 1'b1;
                end
                OP_RIGHT:
                begin
                    cur_next = cur_reg + 1'b1;
                    ptr_next = len_reg;
                end
                OP_LEFT:
                begin
                    cur_next = cur_reg - 1'b1;
                    ptr_next = len_reg;
                end
                OP_UP:
                begin
                    len_next = hlen_rd;
                    cur_next = hlen_rd;
                    rec_next = rec_reg + 1'b1;
                    hp_next  = p_wr[HW-1:0];
                end
                OP_DOWN:
                begin
                    len_next = hlen_rd;
                    cur_next = hlen_rd;
                    rec_next = rec_reg - 1'b1;
                    hp_next  = p_wr[HW-1:0];
                end
                OP_CR:
                begin
                    rec_next = '0;
                    hp_next  = head_reg;
                end
                default:
                begin
                    ptr_next = ptr_reg;
                end
            endcase
        end
        else
        begin
            if (cmd.ptr_clr)
                ptr_next = '0;
            else if (cmd.ptr_inc)
                ptr_next = ptr_reg + 1'b1;
            if (cmd.len_dec || cmd.shift_left)
                len_next = len_reg - 1'b1;
            if (cmd.push)
            begin
                head_next = head_dec;
                hp_next   = head_dec;
            end
            if (cmd.line_clear)
            begin
                len_next = '0;
                cur_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            cur_reg       <= '0;
            ptr_reg       <= '0;
            esc_reg       <= ESC_NONE;
            rec_reg       <= '0;
            head_reg      <= '0;
            hp_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++)
                hlen_reg[i] <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            cur_reg  <= cur_next;
            ptr_reg  <= ptr_next;
            esc_reg  <= esc_next;
            rec_reg  <= rec_next;
            head_reg <= head_next;
            hp_reg   <= hp_next;
            if (cmd.push)
                hlen_reg[head_dec] <= len_reg;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LINE_LEN; i++)
            line_reg[i] <= line_next[i];
        if (cmd.emit)
        begin
            out_byte_reg <= cmd.src_rom ? rom_byte(cmd.rom_idx) : line_rd;
            out_kind_reg <= cmd.kind;
            out_done_reg <= cmd.done;
            out_last_reg <= cmd.last;
        end
    end

    // history entry store
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[maddr] <= line_rd;
        mem_q_reg <= mem[maddr];
    end

    assign stat.op           = op;
    assign stat.out_free     = !out_valid_reg || out_ready;
    assign stat.tail_empty   = ptr_reg >= len_reg;
    assign stat.tail_lastone = ({1'b0, ptr_reg} + 1'b1) >= {1'b0, len_reg};
    assign stat.trail_sp     = (len_reg != '0) && (line_rd == CH_SP);
    assign stat.lead_sp      = (len_reg != '0) && (line_reg[0] == CH_SP);
    assign stat.len_zero     = len_reg == '0;
    assign stat.hlen_ne      = hlen_rd != len_reg;
    assign stat.byte_eq      = mem_q_reg == line_rd;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_kind  = out_kind_reg;
    assign line_done = out_done_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

### hw/rtl/tle_ctrl.sv
// sequencing state machine of the terminal line editor
`timescale 1ns / 1ps
`default_nettype none

module tle_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tle_pkg::stat_t stat,
    output tle_pkg::cmd_t  cmd
);
    import tle_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RC_A    = 4'd1;
    localparam logic [3:0] S_RC_B    = 4'd2;
    localparam logic [3:0] S_TT      = 4'd3;
    localparam logic [3:0] S_LT      = 4'd4;
    localparam logic [3:0] S_CMP_LEN = 4'd5;
    localparam logic [3:0] S_CMP_A   = 4'd6;
    localparam logic [3:0] S_CMP_B   = 4'd7;
    localparam logic [3:0] S_SV_HEAD = 4'd8;
    localparam logic [3:0] S_SV_WR   = 4'd9;
    localparam logic [3:0] S_EM_PRE  = 4'd10;
    localparam logic [3:0] S_EM_TAIL = 4'd11;
    localparam logic [3:0] S_EM_POST = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [3:0] op_reg, op_next;
    logic [4:0] rom_reg, rom_next;
    logic [3:0] op_cur;
    prog_t      pg;
    logic       post_empty;
    logic       is_cr;
    logic       rom_end;

    assign op_cur     = (state_reg == S_IDLE) ? stat.op : op_reg;
    assign pg         = prog_of(op_cur);
    assign post_empty = pg.post_s == pg.post_e;
    assign is_cr      = op_cur == OP_CR;
    assign in_ready   = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        rom_next   = rom_reg;
        rom_end    = 1'b0;
        cmd.rom_idx = rom_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (in_valid)
                begin
                    op_next = stat.op;
                    case (stat.op)
                        OP_NONE:
                            state_next = S_IDLE;
                        OP_UP, OP_DOWN:
                            state_next = S_RC_A;
                        OP_CR:
                            state_next = S_TT;
                        default:
                        begin
                            state_next = S_EM_PRE;
                            rom_next   = pg.pre_s;
                        end
                    endcase
                end
            end
            S_RC_A:
                state_next = S_RC_B;
            S_RC_B:
            begin
                cmd.rc_write = 1'b1;
                if (stat.tail_lastone)
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = S_EM_PRE;
                    rom_next    = pg.pre_s;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_RC_A;
                end
            end
            S_TT:
            begin
                cmd.rd_last = 1'b1;
                if (stat.trail_sp)
                    cmd.len_dec = 1'b1;
                else
                    state_next = S_LT;
            end
            S_LT:
            begin
                if (stat.lead_sp)
                    cmd.shift_left = 1'b1;
                else if (stat.len_zero)
                begin
                    state_next = S_EM_PRE;
                    rom_next   = pg.pre_s;
                end
                else
                    state_next = S_CMP_LEN;
            end
            S_CMP_LEN:
                state_next = stat.hlen_ne ? S_SV_HEAD : S_CMP_A;
            S_CMP_A:
                state_next = S_CMP_B;
            S_CMP_B:
            begin
                if (!stat.byte_eq)
                    state_next = S_SV_HEAD;
                else if (stat.tail_lastone)
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = S_EM_PRE;
                    rom_next    = pg.pre_s;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_CMP_A;
                end
            end
            S_SV_HEAD:
            begin
                cmd.push    = 1'b1;
                cmd.ptr_clr = 1'b1;
                state_next  = S_SV_WR;
            end
            S_SV_WR:
            begin
                cmd.mem_we = 1'b1;
                if (stat.tail_lastone)
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = S_EM_PRE;
                    rom_next    = pg.pre_s;
                end
                else
                    cmd.ptr_inc = 1'b1;
            end
            S_EM_PRE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.src_rom = 1'b1;
                    cmd.last    = (rom_reg + 1'b1 == pg.pre_e) && stat.tail_empty
                                  && post_empty;
                    cmd.done    = cmd.last && is_cr;
                    rom_next    = rom_reg + 1'b1;
                    if (rom_reg + 1'b1 == pg.pre_e)
                    begin
                        if (!stat.tail_empty)
                            state_next = S_EM_TAIL;
                        else if (!post_empty)
                        begin
                            state_next = S_EM_POST;
                            rom_next   = pg.post_s;
                        end
                        else
                            rom_end = 1'b1;
                    end
                end
            end
            S_EM_TAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = is_cr;
                    cmd.last    = stat.tail_lastone && post_empty;
                    cmd.done    = cmd.last && is_cr;
                    cmd.ptr_inc = 1'b1;
                    if (stat.tail_lastone)
                    begin
                        if (!post_empty)
                        begin
                            state_next = S_EM_POST;
                            rom_next   = pg.post_s;
                        end
                        else
                            rom_end = 1'b1;
                    end
                end
            end
            S_EM_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.src_rom = 1'b1;
                    cmd.last    = rom_reg + 1'b1 == pg.post_e;
                    rom_next    = rom_reg + 1'b1;
                    rom_end     = cmd.last;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        // end of the echo program
        if (rom_end)
        begin
            state_next     = S_IDLE;
            cmd.line_clear = is_cr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NONE;
            rom_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            rom_reg   <= rom_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/terminal_line_editor.sv
// top level of the terminal line editor with echo and history recall
//
//  channel | direction | payload                              | handshake
//  in      | sink      | rx_byte                              | in_valid / in_ready
//  out     | source    | out_byte, out_kind, line_done, last  | out_valid / out_ready
//
// one transaction in at a time; once it is taken, one result byte per cycle
// while out_ready stays high (up to 42 results with the default LINE_LEN).
// history recall first copies each recalled byte from the history memory.
// enter first trims trailing and then leading spaces; on a non-empty line it
// checks the length against the newest history entry, compares each byte
// with it and, when the line differs, saves the line as a new entry.
// reset is immediate, no clearing pass; a stalled out channel holds the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module terminal_line_editor #(
    parameter int LINE_LEN   = tle_pkg::LINE_LEN_DEF,
    parameter int HIST_DEPTH = tle_pkg::HIST_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_kind,
    output logic       line_done,
    output logic       last
);
    import tle_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tle_datapath #(
        .LINE_LEN   (LINE_LEN),
        .HIST_DEPTH (HIST_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .rx_byte   (rx_byte),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .out_kind  (out_kind),
        .line_done (line_done),
        .last      (last),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

### hw/rtl/tle_checker.sv
// port-level checker of the terminal line editor and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "terminal_line_editor_defines.svh"

module tle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_kind,
    input logic       line_done,
    input logic       last
);

    `TLE_ASSERT_IMP(a_done_is_last, out_valid && line_done, last)
    `TLE_ASSERT_IMP(a_done_no_trail_space, out_valid && line_done && out_kind, out_byte != 8'h20)
    `TLE_ASSERT_IMP(a_empty_done_newline, out_valid && line_done && !out_kind, out_byte == 8'h0a)
    `TLE_ASSERT_IMP(a_line_printable, out_valid && out_kind, out_byte >= 8'h20 && out_byte <= 8'h7e)
    `TLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last))

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .line_done (line_done),
    .last      (last)
);

`default_nettype wire
